@@ src/flpwc_pkg.sv @@
// ----------------------------------------------------------------------------
// flpwc_pkg
// shared types, constants and helpers for the four-level page walk check
// ----------------------------------------------------------------------------
package flpwc_pkg;

	localparam int unsigned PHYS_ADDR_BITS = 52;
	localparam int unsigned VA_BITS        = 48;
	localparam int unsigned IDX_BITS       = 9;

	localparam logic [63:0] PAGE_LOW_MASK = 64'h0000_0000_0000_0FFF;
	localparam logic [63:0] FRAME_MASK    =
		((64'd1 << PHYS_ADDR_BITS) - 64'd1) & ~PAGE_LOW_MASK;

	localparam int unsigned BIT_PRESENT = 0;
	localparam int unsigned BIT_SIZE    = 7;

	localparam logic OP_START = 1'b0;
	localparam logic OP_ENTRY = 1'b1;

	localparam logic KIND_READ   = 1'b0;
	localparam logic KIND_ANSWER = 1'b1;

	localparam logic [1:0] LEVEL_TOP  = 2'd0;
	localparam logic [1:0] LEVEL_DIR  = 2'd1;
	localparam logic [1:0] LEVEL_MID  = 2'd2;
	localparam logic [1:0] LEVEL_LAST = 2'd3;

	localparam logic CFG_TABLE_ROOT = 1'b0;
	localparam logic CFG_MAP_OFFSET = 1'b1;

	typedef struct packed {
		logic                busy;
		logic [1:0]          level;
		logic [VA_BITS-1:0]  held;
	} walk_state_t;

	typedef struct packed {
		logic                op;
		logic [VA_BITS-1:0]  virt_addr;
		logic [63:0]         entry_data;
	} walk_item_t;

	typedef struct packed {
		logic        valid;
		logic        kind;
		logic [63:0] read_addr;
		logic        mapped;
	} walk_result_t;

	function automatic logic [63:0] entry_address(
		input logic [63:0]        offset,
		input logic [63:0]        base,
		input logic [VA_BITS-1:0] held,
		input logic [1:0]         level
	);
		logic [IDX_BITS-1:0] idx;
		case (level)
			LEVEL_TOP:  idx = held[47:39];
			LEVEL_DIR:  idx = held[38:30];
			LEVEL_MID:  idx = held[29:21];
			LEVEL_LAST: idx = held[20:12];
			default:    idx = held[47:39];
		endcase
		return offset + base + {52'd0, idx, 3'b000};
	endfunction

endpackage

@@ src/flpwc_walk_step.sv @@
// ----------------------------------------------------------------------------
// flpwc_walk_step
// next walk state and result word for one registered input word
// ----------------------------------------------------------------------------
module flpwc_walk_step (
	input  flpwc_pkg::walk_state_t  st,
	input  flpwc_pkg::walk_item_t   item,
	input  logic [63:0]             table_root,
	input  logic [63:0]             map_offset,
	output flpwc_pkg::walk_state_t  st_nxt,
	output flpwc_pkg::walk_result_t res
);
	import flpwc_pkg::*;

	logic       present;
	logic       size_bit;
	logic [1:0] level_inc;

	assign present   = item.entry_data[BIT_PRESENT];
	assign size_bit  = item.entry_data[BIT_SIZE];
	assign level_inc = st.level + 2'd1;

	always_comb begin
		st_nxt        = st;
		res.valid     = 1'b0;
		res.kind      = KIND_READ;
		res.read_addr = 64'd0;
		res.mapped    = 1'b0;
		if (item.op == OP_START) begin
			if (!st.busy) begin
				st_nxt.busy   = 1'b1;
				st_nxt.level  = LEVEL_TOP;
				st_nxt.held   = item.virt_addr;
				res.valid     = 1'b1;
				res.read_addr = entry_address(map_offset, table_root & ~PAGE_LOW_MASK,
					item.virt_addr, LEVEL_TOP);
			end
		end else if (st.busy) begin
			res.valid = 1'b1;
			if (!present) begin
				st_nxt.busy  = 1'b0;
				st_nxt.level = LEVEL_TOP;
				res.kind     = KIND_ANSWER;
			end else if (st.level == LEVEL_LAST ||
				((st.level == LEVEL_DIR || st.level == LEVEL_MID) && size_bit)) begin
				st_nxt.busy  = 1'b0;
				st_nxt.level = LEVEL_TOP;
				res.kind     = KIND_ANSWER;
				res.mapped   = 1'b1;
			end else begin
				st_nxt.level  = level_inc;
				res.read_addr = entry_address(map_offset, item.entry_data & FRAME_MASK,
					st.held, level_inc);
			end
		end
	end

endmodule

@@ src/four_level_page_walk_check.sv @@
// ----------------------------------------------------------------------------
// four_level_page_walk_check
// checks whether a 48-bit virtual address is mapped by a four-level page table
//
// input channel (in_valid / in_stall): op 0 starts a lookup of virt_addr,
// op 1 returns a table entry in entry_data. words in the wrong phase are
// dropped without a result.
// output channel (out_valid / out_stall): kind 0 is a read request at
// read_addr, kind 1 is the final answer in mapped.
// config channel (cfg_valid / cfg_ready): index 0 table_root, index 1
// direct_map_offset; always ready, write only while no walk is in flight.
// a word accepted into the input register passes one step of logic into
// the result register. throughput: one word per cycle while the receiver
// does not stall, set by the single-step next-state logic.
// when the receiver stalls, the result register holds and the input
// register fills; in_stall rises only when both are occupied.
// reset clears the walk state, both config registers and all valid flags.
// ----------------------------------------------------------------------------
module four_level_page_walk_check (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [63:0]                  cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  logic [flpwc_pkg::VA_BITS-1:0] virt_addr,
	input  logic [63:0]                  entry_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         kind,
	output logic [63:0]                  read_addr,
	output logic                         mapped
);
	import flpwc_pkg::*;

	logic [63:0]  root_q;
	logic [63:0]  offset_q;
	walk_state_t  st_q;
	walk_state_t  st_nxt;
	logic         valid_s1;
	walk_item_t   item_s1;
	walk_result_t res;
	walk_result_t res_s2;
	logic         advance;

	assign cfg_ready    = 1'b1;
	assign advance      = !res_s2.valid || !out_stall;
	assign in_stall     = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q   <= 64'd0;
			offset_q <= 64'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TABLE_ROOT: root_q   <= cfg_data;
				CFG_MAP_OFFSET: offset_q <= cfg_data;
				default:        root_q   <= root_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.op         <= op;
			item_s1.virt_addr  <= virt_addr;
			item_s1.entry_data <= entry_data;
		end
	end

	flpwc_walk_step u_step (
		.st         (st_q),
		.item       (item_s1),
		.table_root (root_q),
		.map_offset (offset_q),
		.st_nxt     (st_nxt),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= '0;
			res_s2 <= '0;
		end else if (advance) begin
			res_s2.valid <= valid_s1 && res.valid;
			if (valid_s1) begin
				st_q <= st_nxt;
			end
			if (valid_s1 && res.valid) begin
				res_s2.kind      <= res.kind;
				res_s2.read_addr <= res.read_addr;
				res_s2.mapped    <= res.mapped;
			end
		end
	end

	assign out_valid = res_s2.valid;
	assign kind      = res_s2.kind;
	assign read_addr = res_s2.read_addr;
	assign mapped    = res_s2.mapped;

	a_answer_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ANSWER |-> read_addr == 64'd0)
		else $error("answer word carries a read address");

	a_read_not_mapped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_READ |-> !mapped)
		else $error("read request word flags mapped");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled with a free slot");

	a_answer_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && res.valid && res.kind == KIND_ANSWER |=> !st_q.busy)
		else $error("walk still busy after its answer");

endmodule
